### hdl/ials_pkg.sv
`timescale 1ns / 1ps
// Package for the indexed array list engine: command and status codes,
// sequencer states and the result bundle. No dependencies.
package ials_pkg;

  typedef enum logic [2:0] {
    CMD_INS_FIRST = 3'd0,
    CMD_INS_LAST  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_AT    = 3'd3,
    CMD_DEL_FIRST = 3'd4,
    CMD_DEL_LAST  = 3'd5,
    CMD_SEARCH    = 3'd6,
    CMD_READ_AT   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_FILL,
    S_SHIFT_DN,
    S_SEARCH,
    S_READ,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         found_position;
    logic signed [31:0] read_value;
    logic [8:0]         entry_count;
  } result_t;

endpackage

### hdl/ials_mem.sv
`timescale 1ns / 1ps
// Entry store: one write port, one read port, registered read data.
// Depends on nothing.
module ials_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [31:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic signed [31:0] rdata
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/ials_seq.sv
`timescale 1ns / 1ps
// Command sequencer: range checks, count register and the read-modify-write
// walks over the entry store. Depends on ials_pkg and ials_mem.
module ials_seq
  import ials_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int AW       = 8,
  parameter int CW       = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [2:0]         command,
  input  logic [8:0]         position,
  input  logic signed [31:0] data_value,
  output logic               busy,
  output logic               res_valid,
  input  logic               res_take,
  output result_t            res
);

  localparam int XW = (CW > 9) ? CW : 9;

  seq_state_t         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      src_r, src_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      found_r, found_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic signed [31:0] rdval_r, rdval_nxt;
  status_t            status_r, status_nxt;

  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic [AW-1:0]      raddr;
  logic signed [31:0] rdata;

  logic [XW-1:0]      pos_x;
  logic [XW-1:0]      cnt_x;
  logic [XW-1:0]      ins_idx_x;
  logic [XW-1:0]      del_idx_x;
  logic [XW-1:0]      found_x;
  logic [CW-1:0]      cnt_m1;
  logic               full;
  logic               empty;
  cmd_t               cmd;

  ials_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r    <= src_nxt;
    idx_r    <= idx_nxt;
    found_r  <= found_nxt;
    val_r    <= val_nxt;
    rdval_r  <= rdval_nxt;
    status_r <= status_nxt;
  end

  assign cmd       = cmd_t'(command);
  assign pos_x     = XW'(position);
  assign cnt_x     = XW'(count_r);
  assign cnt_m1    = count_r - 1'b1;
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign ins_idx_x = (cmd == CMD_INS_FIRST) ? '0 :
                     (cmd == CMD_INS_LAST)  ? cnt_x : pos_x;
  assign del_idx_x = (cmd == CMD_DEL_FIRST) ? '0 : pos_x;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    src_nxt    = src_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    val_nxt    = val_r;
    rdval_nxt  = rdval_r;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = src_r;
    wdata      = rdata;
    raddr      = src_r;

    case (state_r)
      S_IDLE: begin
        if (go) begin
          status_nxt = ST_OK;
          found_nxt  = '0;
          rdval_nxt  = '0;
          val_nxt    = data_value;
          state_nxt  = S_DONE;
          case (cmd)
            CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
              if (cmd == CMD_INS_AT && pos_x > cnt_x) begin
                status_nxt = ST_RANGE;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else if (ins_idx_x == cnt_x) begin
                // append: no entries move
                we        = 1'b1;
                waddr     = count_r[AW-1:0];
                wdata     = data_value;
                count_nxt = count_r + 1'b1;
              end else begin
                raddr     = cnt_m1[AW-1:0];
                src_nxt   = cnt_m1[AW-1:0];
                idx_nxt   = ins_idx_x[AW-1:0];
                state_nxt = S_SHIFT_UP;
              end
            end
            CMD_DEL_AT, CMD_DEL_FIRST: begin
              if (del_idx_x >= cnt_x) begin
                status_nxt = (cmd == CMD_DEL_AT) ? ST_RANGE : ST_EMPTY;
              end else if (del_idx_x == XW'(cnt_m1)) begin
                count_nxt = cnt_m1;
              end else begin
                raddr     = del_idx_x[AW-1:0] + 1'b1;
                src_nxt   = del_idx_x[AW-1:0] + 1'b1;
                state_nxt = S_SHIFT_DN;
              end
            end
            CMD_DEL_LAST: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = cnt_m1;
              end
            end
            CMD_SEARCH: begin
              if (empty) begin
                status_nxt = ST_NOTFOUND;
              end else begin
                raddr     = '0;
                src_nxt   = '0;
                state_nxt = S_SEARCH;
              end
            end
            CMD_READ_AT: begin
              if (pos_x >= cnt_x) begin
                status_nxt = ST_RANGE;
              end else begin
                raddr     = pos_x[AW-1:0];
                state_nxt = S_READ;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      // read src-1 while writing src+1: the two never collide
      S_SHIFT_UP: begin
        we    = 1'b1;
        waddr = src_r + 1'b1;
        wdata = rdata;
        if (src_r == idx_r) begin
          state_nxt = S_FILL;
        end else begin
          raddr   = src_r - 1'b1;
          src_nxt = src_r - 1'b1;
        end
      end
      S_FILL: begin
        we        = 1'b1;
        waddr     = idx_r;
        wdata     = val_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_SHIFT_DN: begin
        we    = 1'b1;
        waddr = src_r - 1'b1;
        wdata = rdata;
        if (CW'(src_r) == cnt_m1) begin
          count_nxt = cnt_m1;
          state_nxt = S_DONE;
        end else begin
          raddr   = src_r + 1'b1;
          src_nxt = src_r + 1'b1;
        end
      end
      S_SEARCH: begin
        if (rdata == val_r) begin
          found_nxt = src_r;
          state_nxt = S_DONE;
        end else if (CW'(src_r) == cnt_m1) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_DONE;
        end else begin
          raddr   = src_r + 1'b1;
          src_nxt = src_r + 1'b1;
        end
      end
      S_READ: begin
        rdval_nxt = rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign found_x            = XW'(found_r);
  assign busy               = (state_r != S_IDLE);
  assign res_valid          = (state_r == S_DONE);
  assign res.status         = status_r;
  assign res.found_position = found_x[7:0];
  assign res.read_value     = rdval_r;
  assign res.entry_count    = cnt_x[8:0];

endmodule

### hdl/indexed_array_list_engine_core.sv
`timescale 1ns / 1ps
// Indexed array list engine: top level with the result register.
// Depends on ials_pkg and ials_seq.
//
// Usage:
//   Requests enter on in_valid/in_stall; a request is taken when in_valid is
//   high and in_stall low. Each request yields exactly one result on
//   out_valid/out_stall, taken when out_valid is high and out_stall low.
//   One request is worked at a time; in_stall stays high until its result
//   has moved into the output register.
//   Appends, delete last and failed checks go from the check straight to the
//   result. Read at reads one entry; inserts and deletes with shifting walk
//   the entries from the index up, and a search walks from entry 0 up to the
//   match or the last entry. The walks move one entry per cycle through the
//   single-read, single-write entry store.
//   Reset clears the count and the control state; the store needs no clear.
//   While out_stall holds, the result waits in the output register and the
//   next request can be worked; its result waits in the sequencer.
module indexed_array_list_engine_core
  import ials_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic [8:0]         in_position,
  input  logic signed [31:0] in_data_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [7:0]         out_found_position,
  output logic signed [31:0] out_read_value,
  output logic [8:0]         out_entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic    busy;
  logic    res_valid;
  logic    res_take;
  result_t res;
  result_t out_r;
  logic    out_valid_r, out_valid_nxt;

  ials_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (in_valid && !in_stall),
    .command    (in_command),
    .position   (in_position),
    .data_value (in_data_value),
    .busy       (busy),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  assign in_stall = busy;
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_found_position = out_r.found_position;
  assign out_read_value     = out_r.read_value;
  assign out_entry_count    = out_r.entry_count;

endmodule

### verif/indexed_array_list_engine_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_array_list_engine_core: directed and random list
// requests, with a list predictor and a scoreboard. Depends on ials_pkg and the core RTL.
module indexed_array_list_engine_core_tb
  import ials_pkg::*;
();

  localparam int CAPACITY         = 256;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int MAX_REPORTS      = 10;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_command;
  logic [8:0]         in_position;
  logic signed [31:0] in_data_value;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_status;
  logic [7:0]         out_found_position;
  logic signed [31:0] out_read_value;
  logic [8:0]         out_entry_count;

  // predicted list contents, kept in step with accepted requests
  logic signed [31:0] model_entries [CAPACITY];
  int                 model_count = 0;
  result_t            pending_results [$];

  int   mismatch_count = 0;
  int   idle_cycles    = 0;
  logic quiet_mode     = 1'b0;
  logic hold_pending   = 1'b0;

  indexed_array_list_engine_core #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_position        (in_position),
    .in_data_value      (in_data_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_read_value     (out_read_value),
    .out_entry_count    (out_entry_count)
  );

  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one; none in quiet stretches
  function automatic int pick_gap();
    int roll;
    if (quiet_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    // small pool so that duplicates show up
    if (roll < 4) return $signed($urandom_range(0, 15)) - 32'sd8;
    return $urandom;
  endfunction

  function automatic status_t shift_in(int idx, logic signed [31:0] val);
    int i;
    if (model_count >= CAPACITY) return ST_FULL;
    for (i = model_count; i > idx; i--) model_entries[i] = model_entries[i - 1];
    model_entries[idx] = val;
    model_count++;
    return ST_OK;
  endfunction

  function automatic void shift_out(int idx);
    int i;
    for (i = idx; i + 1 < model_count; i++) model_entries[i] = model_entries[i + 1];
    model_count--;
  endfunction

  function automatic result_t apply_list_command(cmd_t cmd, logic [8:0] pos,
                                                 logic signed [31:0] val);
    result_t res;
    int      i;
    int      where;
    where              = int'(pos);
    res.status         = ST_OK;
    res.found_position = '0;
    res.read_value     = '0;
    case (cmd)
      CMD_INS_FIRST: res.status = shift_in(0, val);
      CMD_INS_LAST:  res.status = shift_in(model_count, val);
      CMD_INS_AT: begin
        // index check wins over the full check
        if (where > model_count) res.status = ST_RANGE;
        else res.status = shift_in(where, val);
      end
      CMD_DEL_AT: begin
        if (where >= model_count) res.status = ST_RANGE;
        else shift_out(where);
      end
      CMD_DEL_FIRST: begin
        if (model_count == 0) res.status = ST_EMPTY;
        else shift_out(0);
      end
      CMD_DEL_LAST: begin
        if (model_count == 0) res.status = ST_EMPTY;
        else model_count--;
      end
      CMD_SEARCH: begin
        res.status = ST_NOTFOUND;
        for (i = 0; i < model_count; i++) begin
          if (res.status == ST_NOTFOUND && model_entries[i] == val) begin
            res.status         = ST_OK;
            res.found_position = i[7:0];
          end
        end
      end
      default: begin
        if (where >= model_count) res.status = ST_RANGE;
        else res.read_value = model_entries[where];
      end
    endcase
    res.entry_count = model_count[8:0];
    return res;
  endfunction

  // called at a falling edge; returns at a falling edge after the request and its gap
  task automatic send_request(cmd_t cmd, logic [8:0] pos, logic signed [31:0] val);
    int gap;
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_position   <= pos;
    in_data_value <= val;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_list_command(cmd, pos, val));
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic note_mismatch(string field_name, longint want, longint got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field_name, want, got);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result with no request outstanding, status %0d", $time, out_status);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          note_mismatch("status", want.status, out_status);
        if (out_found_position !== want.found_position)
          note_mismatch("found_position", want.found_position, out_found_position);
        if (out_read_value !== want.read_value)
          note_mismatch("read_value", want.read_value, out_read_value);
        if (out_entry_count !== want.entry_count)
          note_mismatch("entry_count", want.entry_count, out_entry_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("indexed_array_list_engine_core regression: fail");
        $finish;
      end
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        stall_left = pick_gap();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_directed_cases();
    // empty list: every failing path
    send_request(CMD_DEL_FIRST, 9'h1FF, 32'sd0);
    send_request(CMD_DEL_LAST, 9'h000, 32'sd0);
    send_request(CMD_SEARCH, 9'h1FF, 32'sd0);
    send_request(CMD_READ_AT, 9'd0, 32'sd0);
    send_request(CMD_DEL_AT, 9'd0, 32'sd0);
    send_request(CMD_INS_AT, 9'd1, 32'sd5);
    // build [0, 7, MIN, MAX, -1]
    send_request(CMD_INS_AT, 9'd0, 32'sh8000_0000);
    send_request(CMD_INS_LAST, 9'h1FF, 32'sh7FFF_FFFF);
    send_request(CMD_INS_FIRST, 9'h155, 32'sd0);
    send_request(CMD_INS_AT, 9'd3, -32'sd1);
    send_request(CMD_INS_AT, 9'd1, 32'sd7);
    send_request(CMD_INS_AT, 9'h1FF, 32'sd9);
    send_request(CMD_READ_AT, 9'h1FF, 32'sd0);
    send_request(CMD_DEL_AT, 9'd5, 32'sd0);
    send_request(CMD_READ_AT, 9'd4, 32'sh7FFF_FFFF);
    send_request(CMD_READ_AT, 9'd2, 32'sd0);
    // duplicate: search must return the first one
    send_request(CMD_INS_LAST, 9'd0, 32'sd7);
    send_request(CMD_SEARCH, 9'd0, 32'sd7);
    send_request(CMD_SEARCH, 9'd0, 32'sh7FFF_FFFF);
    send_request(CMD_SEARCH, 9'd0, 32'sd12345);
    send_request(CMD_DEL_AT, 9'd1, 32'sd0);
    send_request(CMD_DEL_FIRST, 9'd0, 32'sd0);
    send_request(CMD_DEL_LAST, 9'd0, 32'sd0);
    send_request(CMD_READ_AT, 9'd2, 32'sd0);
  endtask

  task automatic test_fill_and_drain();
    int   n;
    cmd_t cmd;
    while (model_count < CAPACITY) begin
      cmd = cmd_t'($urandom_range(0, 2));
      send_request(cmd, 9'($urandom_range(0, model_count)), pick_value());
    end
    // full list: full vs. range ordering, longest walks
    send_request(CMD_INS_FIRST, 9'd0, 32'sd1);
    send_request(CMD_INS_LAST, 9'd0, 32'sd1);
    send_request(CMD_INS_AT, 9'd256, 32'sd1);
    send_request(CMD_INS_AT, 9'd257, 32'sd1);
    send_request(CMD_SEARCH, 9'd0, model_entries[CAPACITY - 1]);
    send_request(CMD_SEARCH, 9'd0, 32'sh1234_5678);
    send_request(CMD_READ_AT, 9'd255, 32'sd0);
    send_request(CMD_READ_AT, 9'd256, 32'sd0);
    send_request(CMD_DEL_AT, 9'd0, 32'sd0);
    n = 0;
    while (model_count > 0) begin
      n++;
      if (n % 8 == 0) begin
        send_request(CMD_SEARCH, 9'($urandom),
                     model_entries[$urandom_range(0, model_count - 1)]);
      end else begin
        cmd = cmd_t'($urandom_range(3, 5));
        send_request(cmd, 9'($urandom_range(0, model_count - 1)), $urandom);
      end
    end
  endtask

  // receiver holds off while requests keep coming, so the core backs up
  task automatic test_output_backpressure();
    int i;
    quiet_mode   = 1'b1;
    hold_pending = 1'b1;
    for (i = 0; i < 12; i++) begin
      case (i % 3)
        0: send_request(CMD_INS_LAST, 9'd0, pick_value());
        1: send_request(CMD_READ_AT, 9'd0, 32'sd0);
        default: send_request(CMD_SEARCH, 9'd0, pick_value());
      endcase
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_traffic(int n_items);
    int                 i;
    int                 grow_pct;
    cmd_t               cmd;
    logic [8:0]         pos;
    logic signed [31:0] val;
    grow_pct = 70;
    for (i = 0; i < n_items; i++) begin
      // drift the insert/delete balance so the count roams empty to full
      if (i % 150 == 0) grow_pct = $urandom_range(15, 90);
      quiet_mode = ((i % 250) >= 200);
      if ($urandom_range(0, 99) < 20)
        cmd = ($urandom_range(0, 1) == 0) ? CMD_SEARCH : CMD_READ_AT;
      else if ($urandom_range(0, 99) < grow_pct)
        cmd = cmd_t'($urandom_range(0, 2));
      else
        cmd = cmd_t'($urandom_range(3, 5));
      if ($urandom_range(0, 99) < 15)
        pos = 9'($urandom);
      else if (cmd == CMD_INS_AT)
        pos = 9'($urandom_range(0, model_count));
      else if (model_count > 0)
        pos = 9'($urandom_range(0, model_count - 1));
      else
        pos = '0;
      if (cmd == CMD_SEARCH && model_count > 0 && $urandom_range(0, 9) < 7)
        val = model_entries[$urandom_range(0, model_count - 1)];
      else
        val = pick_value();
      send_request(cmd, pos, val);
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_INS_FIRST;
    in_position   = '0;
    in_data_value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_fill_and_drain();
    test_output_backpressure();
    test_random_traffic(950);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("indexed_array_list_engine_core regression: pass");
    else
      $display("indexed_array_list_engine_core regression: fail");
    $finish;
  end

endmodule
